### rtl/salc_pkg.sv
// Shared codes, widths and helpers for the set-associative LRU cache model.
package salc_pkg;

    localparam int ADDR_W     = 32;
    localparam int TAG_W      = 32;
    localparam int COUNT_W    = 32;
    localparam int WAYS_CNT_W = 5;   // holds the 4-bit ways field and MAX_WAYS up to 16

    localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

    // Trace access kinds
    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_STORE  = 2'd1;
    localparam logic [1:0] ACT_MODIFY = 2'd2;
    localparam logic [1:0] ACT_NONE   = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_SET_BITS   = 2'd0;
    localparam logic [1:0] REG_WAYS       = 2'd1;
    localparam logic [1:0] REG_BLOCK_BITS = 2'd2;

    typedef struct packed {
        logic hit;
        logic evicted;
    } upd_status_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    // Tag is the address above offset and set bits; zero once the shift reaches the width.
    function automatic logic [TAG_W-1:0] tag_of(input logic [ADDR_W-1:0] a,
                                                input logic [3:0] sb,
                                                input logic [4:0] bb);
        logic [5:0] sh;
        sh = {2'b00, sb} + {1'b0, bb};
        return (sh >= 6'd32) ? '0 : (a >> sh);
    endfunction

endpackage

### rtl/salc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/salc_update.sv
// Per-set lookup and LRU update: hit search, fill or victim choice, new ranks.
module salc_update
    import salc_pkg::*;
#(
    parameter int MAX_WAYS = 8
) (
    input  logic [MAX_WAYS-1:0][TAG_W-1:0]                    tags_in,
    input  logic [MAX_WAYS-1:0]                               valid_in,
    input  logic [MAX_WAYS-1:0][(MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1)-1:0] rank_in,
    input  logic [WAYS_CNT_W-1:0]                             nw,
    input  logic [TAG_W-1:0]                                  tag,
    output logic [MAX_WAYS-1:0][TAG_W-1:0]                    tags_out,
    output logic [MAX_WAYS-1:0]                               valid_out,
    output logic [MAX_WAYS-1:0][(MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1)-1:0] rank_out,
    output upd_status_t                                       status
);

    localparam int RW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam logic [RW-1:0] RANK_TOP = RW'(MAX_WAYS - 1);

    function automatic logic [RW-1:0] rank_inc(input logic [RW-1:0] r);
        return (r >= RANK_TOP) ? RANK_TOP : r + 1'b1;
    endfunction

    always_comb
    begin
        logic [MAX_WAYS-1:0] vis;
        logic                hit;
        logic                have_free;
        logic [WW-1:0]       hit_way;
        logic [WW-1:0]       free_way;
        logic [WW-1:0]       victim;
        logic [WW-1:0]       slot;
        logic [RW-1:0]       vmax;
        logic [RW-1:0]       hit_rank;

        for (int w = 0; w < MAX_WAYS; w++)
        begin
            vis[w] = (WAYS_CNT_W'(w) < nw);
        end

        // Lowest visible valid way with a matching tag, lowest visible free way
        hit       = 1'b0;
        have_free = 1'b0;
        hit_way   = '0;
        free_way  = '0;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (vis[w] && valid_in[w])
            begin
                if (!hit && tags_in[w] == tag)
                begin
                    hit     = 1'b1;
                    hit_way = WW'(w);
                end
            end
            else if (vis[w] && !have_free)
            begin
                have_free = 1'b1;
                free_way  = WW'(w);
            end
        end

        // Greatest rank among visible ways; ties keep the lowest way
        victim = '0;
        vmax   = rank_in[0];
        for (int w = 1; w < MAX_WAYS; w++)
        begin
            if (vis[w] && rank_in[w] > vmax)
            begin
                victim = WW'(w);
                vmax   = rank_in[w];
            end
        end

        hit_rank  = rank_in[hit_way];
        tags_out  = tags_in;
        valid_out = valid_in;
        rank_out  = rank_in;
        slot      = have_free ? free_way : victim;

        if (hit)
        begin
            for (int w = 0; w < MAX_WAYS; w++)
            begin
                if (vis[w] && valid_in[w] && WW'(w) != hit_way && rank_in[w] < hit_rank)
                begin
                    rank_out[w] = rank_inc(rank_in[w]);
                end
            end
            rank_out[hit_way] = '0;
        end
        else
        begin
            for (int w = 0; w < MAX_WAYS; w++)
            begin
                if (have_free)
                begin
                    if (vis[w] && valid_in[w])
                    begin
                        rank_out[w] = rank_inc(rank_in[w]);
                    end
                end
                else if (vis[w] && WW'(w) != victim && rank_in[w] < vmax)
                begin
                    rank_out[w] = rank_inc(rank_in[w]);
                end
            end
            tags_out[slot]  = tag;
            valid_out[slot] = 1'b1;
            rank_out[slot]  = '0;
        end

        status.hit     = hit;
        status.evicted = !hit && !have_free;
    end

endmodule

### rtl/set_assoc_lru_cache_sim.sv
// Top level of the set-associative LRU cache simulator: sequencer, set RAM, counters.
//
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tuser = action[1:0], tdata = address[31:0]
//  m_axis    out  tvalid/tready          tdata = hit, evicted, hit_total, miss_total,
//                                        eviction_total; tlast = last
//  apb       in   psel/penable/pready    set_bits @0x0, ways @0x4, block_bits @0x8
//
// A load or store: the accept cycle issues the set read, then the update state merges
// the row and writes it back once the output register is free. A modify adds a second
// read of the same set after the write-back and a second update. Action 3 takes the
// accept cycle only. The sequence follows from the registered read of the single set
// RAM and its read-modify-write. After reset a clearing pass writes every set row once
// with s_axis_tready low; APB writes are taken meanwhile. A result waits in the output
// register; an update stalls until that register is free, and a new transfer is
// accepted while the last result still waits.
module set_assoc_lru_cache_sim
    import salc_pkg::*;
#(
    parameter int MAX_SET_BITS = 8,
    parameter int MAX_WAYS     = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    // input stream
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [31:0]   s_axis_tdata,   // address[31:0]
    input  logic [1:0]    s_axis_tuser,   // action[1:0]
    // result stream
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [103:0]  m_axis_tdata,   // hit[0], evicted[1], hit_total[33:2],
                                          // miss_total[65:34], eviction_total[97:66]
    output logic          m_axis_tlast,
    // configuration
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int SW      = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int ROWS    = 1 << MAX_SET_BITS;
    localparam int RW      = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int ROW_W   = MAX_WAYS * (TAG_W + 1 + RW);
    localparam int TAGS_W  = MAX_WAYS * TAG_W;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_LOOKUP = 3'd2;
    localparam logic [2:0] ST_UPDATE = 3'd3;

    // configuration registers
    logic [3:0] set_bits_reg;
    logic [3:0] ways_reg;
    logic [4:0] block_bits_reg;

    logic [2:0]          state_reg, state_next;
    logic [SW-1:0]       clr_cnt_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic                modify_reg;
    logic [COUNT_W-1:0]  hit_cnt_reg, hit_cnt_next;
    logic [COUNT_W-1:0]  miss_cnt_reg, miss_cnt_next;
    logic [COUNT_W-1:0]  evict_cnt_reg, evict_cnt_next;
    logic                out_valid_reg;
    logic                out_hit_reg;
    logic                out_evicted_reg;
    logic                out_last_reg;
    logic [COUNT_W-1:0]  out_hit_total_reg;
    logic [COUNT_W-1:0]  out_miss_total_reg;
    logic [COUNT_W-1:0]  out_evict_total_reg;

    logic                in_fire;
    logic                out_free;
    logic                upd_fire;
    logic                ram_we;
    logic                ram_re;
    logic [SW-1:0]       ram_waddr;
    logic [SW-1:0]       ram_raddr;
    logic [ROW_W-1:0]    ram_wdata;
    logic [ROW_W-1:0]    ram_rdata;
    logic [ROW_W-1:0]    row_new;
    logic [3:0]          sb;
    logic [WAYS_CNT_W-1:0] nw;
    logic [ADDR_W-1:0]   rd_addr;
    logic [TAG_W-1:0]    upd_tag;
    upd_status_t         upd_status;

    logic [MAX_WAYS-1:0][TAG_W-1:0] tags_new;
    logic [MAX_WAYS-1:0]            valid_new;
    logic [MAX_WAYS-1:0][RW-1:0]    rank_new;

    function automatic logic [SW-1:0] set_of(input logic [ADDR_W-1:0] a,
                                             input logic [3:0] s,
                                             input logic [4:0] b);
        logic [ADDR_W-1:0] mask;
        mask = (ADDR_W'(1) << s) - 1'b1;
        return SW'((a >> b) & mask);
    endfunction

    // Clamp the geometry to what the storage holds
    always_comb
    begin
        sb = (set_bits_reg > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : set_bits_reg;
        if (ways_reg == '0)
        begin
            nw = WAYS_CNT_W'(1);
        end
        else if ({1'b0, ways_reg} > WAYS_CNT_W'(MAX_WAYS))
        begin
            nw = WAYS_CNT_W'(MAX_WAYS);
        end
        else
        begin
            nw = {1'b0, ways_reg};
        end
    end

    // APB: always ready, reads return the register value
    assign pready = 1'b1;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_SET_BITS:   prdata = {28'd0, set_bits_reg};
            REG_WAYS:       prdata = {28'd0, ways_reg};
            REG_BLOCK_BITS: prdata = {27'd0, block_bits_reg};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg   <= 4'd4;
            ways_reg       <= 4'd1;
            block_bits_reg <= 5'd4;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (paddr[3:2])
                REG_SET_BITS:   set_bits_reg   <= pwdata[3:0];
                REG_WAYS:       ways_reg       <= pwdata[3:0];
                REG_BLOCK_BITS: block_bits_reg <= pwdata[4:0];
                default:        ;
            endcase
        end
    end

    // Handshakes. Transfers are taken only in idle, so a read never overlaps the
    // write-back of the same set: the write lands before the next read is issued.
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign upd_fire      = (state_reg == ST_UPDATE) && out_free;

    // Read the set addressed by the arriving transfer, or by the held one
    assign rd_addr   = (state_reg == ST_IDLE) ? s_axis_tdata : addr_reg;
    assign ram_raddr = set_of(rd_addr, sb, block_bits_reg);
    assign ram_re    = (in_fire && s_axis_tuser != ACT_NONE) || (state_reg == ST_LOOKUP);
    assign upd_tag   = tag_of(addr_reg, sb, block_bits_reg);

    salc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    ) u_set_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    salc_update #(
        .MAX_WAYS (MAX_WAYS)
    ) u_update (
        .tags_in   (ram_rdata[TAGS_W-1:0]),
        .valid_in  (ram_rdata[TAGS_W +: MAX_WAYS]),
        .rank_in   (ram_rdata[TAGS_W + MAX_WAYS +: MAX_WAYS * RW]),
        .nw        (nw),
        .tag       (upd_tag),
        .tags_out  (tags_new),
        .valid_out (valid_new),
        .rank_out  (rank_new),
        .status    (upd_status)
    );

    assign row_new = {rank_new, valid_new, tags_new};

    // Write back the merged row, or zeros during the clearing pass
    assign ram_we    = upd_fire || (state_reg == ST_CLEAR);
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg
                                               : set_of(addr_reg, sb, block_bits_reg);
    assign ram_wdata = (state_reg == ST_CLEAR) ? '0 : row_new;

    // Running totals, saturating
    always_comb
    begin
        hit_cnt_next   = hit_cnt_reg;
        miss_cnt_next  = miss_cnt_reg;
        evict_cnt_next = evict_cnt_reg;
        if (upd_fire)
        begin
            if (upd_status.hit)
            begin
                hit_cnt_next = sat_inc(hit_cnt_reg);
            end
            else
            begin
                miss_cnt_next = sat_inc(miss_cnt_reg);
            end
            if (upd_status.evicted)
            begin
                evict_cnt_next = sat_inc(evict_cnt_reg);
            end
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == SW'(ROWS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire && s_axis_tuser != ACT_NONE)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (upd_fire)
                begin
                    state_next = modify_reg ? ST_LOOKUP : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            modify_reg    <= 1'b0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            evict_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hit_cnt_reg   <= hit_cnt_next;
            miss_cnt_reg  <= miss_cnt_next;
            evict_cnt_reg <= evict_cnt_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (in_fire)
            begin
                modify_reg <= (s_axis_tuser == ACT_MODIFY);
            end
            else if (upd_fire)
            begin
                modify_reg <= 1'b0;
            end
            // Hold the result until taken; load a new one as the slot frees
            if (upd_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            addr_reg <= s_axis_tdata;
        end
        if (upd_fire)
        begin
            out_hit_reg         <= upd_status.hit;
            out_evicted_reg     <= upd_status.evicted;
            out_last_reg        <= !modify_reg;
            out_hit_total_reg   <= hit_cnt_next;
            out_miss_total_reg  <= miss_cnt_next;
            out_evict_total_reg <= evict_cnt_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {6'd0, out_evict_total_reg, out_miss_total_reg,
                            out_hit_total_reg, out_evicted_reg, out_hit_reg};

`ifndef ASSERT_OFF
    // No transfer is taken while the clearing pass runs
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !s_axis_tready)
        else $error("input accepted during clearing pass");

    // A blocked result holds the update: no write-back and no state advance
    a_update_interlock: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE && m_axis_tvalid && !m_axis_tready)
            |-> (!ram_we ##1 state_reg == ST_UPDATE))
        else $error("update advanced while result blocked");

    // A hit never evicts
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("result flags hit and eviction together");

    // The first half of a modify is followed by its second read
    a_modify_second: assert property (@(posedge clk) disable iff (!rst_n)
        (upd_fire && modify_reg) |=> (state_reg == ST_LOOKUP && !out_last_reg))
        else $error("modify did not issue its second update");
`endif

endmodule
